[src/opb_clp_pkg.sv]
// Shared types and constants for the OPB constraint line parser.
// Holds field widths, character codes, parse phases and the result record.
// No dependencies.
package opb_clp_pkg;

  localparam int VARIABLE_BITS = 20;
  localparam int NUMBER_BITS   = 31;
  localparam int INDEX_BITS    = 20;

  // Common width for comparing a parsed number against the variable limit.
  localparam int CMP_BITS = (NUMBER_BITS > VARIABLE_BITS) ? NUMBER_BITS : VARIABLE_BITS;

  localparam logic [NUMBER_BITS-1:0]   NUM_MAX = '1;
  localparam logic [VARIABLE_BITS-1:0] VAR_MAX = '1;
  localparam logic [INDEX_BITS-1:0]    IDX_MAX = '1;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_SKIP       = 4'd1,
    PH_OBJ_M      = 4'd2,
    PH_OBJ_MIN    = 4'd3,
    PH_OBJ_MAX    = 4'd4,
    PH_TERM_START = 4'd5,
    PH_TERM_COEF  = 4'd6,
    PH_TERM_VAR   = 4'd7,
    PH_CMP_GE     = 4'd8,
    PH_CONST_SIGN = 4'd9,
    PH_CONST_DIG  = 4'd10
  } phase_e;

  typedef enum logic [1:0] {
    KIND_TERM    = 2'd0,
    KIND_CEND    = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_SUMMARY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_MISSING_X = 2'd1,
    ERR_BAD_CMP   = 2'd2,
    ERR_NO_SEMI   = 2'd3
  } err_e;

  typedef struct packed {
    kind_e                    kind;
    logic [INDEX_BITS-1:0]    idx;
    logic [VARIABLE_BITS:0]   literal;
    logic [NUMBER_BITS-1:0]   coef;
    logic [NUMBER_BITS:0]     constant;
    logic                     is_eq;
    logic [VARIABLE_BITS-1:0] max_var;
    logic [INDEX_BITS-1:0]    count;
    err_e                     err;
    logic                     last;
  } result_t;

  // Up to two results per item, in order.
  typedef struct packed {
    logic [1:0] num;
    result_t    r0;
    result_t    r1;
  } result_pair_t;

endpackage

[src/opb_clp_parser.sv]
// Parse state machine and datapath: consumes one character per item and
// produces up to two results. Depends on opb_clp_pkg.
module opb_clp_parser
  import opb_clp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   text_byte_i,
  input  logic         end_of_input_i,
  output result_pair_t res_o
);

  phase_e                   phase_q, phase_d;
  logic [1:0]               obj_q, obj_d;
  logic [NUMBER_BITS-1:0]   acc_q, acc_d;
  logic [NUMBER_BITS-1:0]   held_q, held_d;
  logic                     tneg_q, tneg_d;
  logic                     cneg_q, cneg_d;
  logic                     eq_q, eq_d;
  logic [VARIABLE_BITS-1:0] maxv_q, maxv_d;
  logic [INDEX_BITS-1:0]    cnt_q, cnt_d;
  logic                     halted_q, halted_d;

  logic [7:0] c;
  logic       kept, c_digit, c_sign, c_neg, toc_run, cc_run;

  logic [NUMBER_BITS+3:0]   prod;
  logic [NUMBER_BITS-1:0]   acc_dig;
  logic [CMP_BITS-1:0]      acc_ext;
  logic [VARIABLE_BITS-1:0] var_val;

  logic term_v, cend_v, err_v, sum_v;
  err_e err_code;

  // End of input closes an open line as a newline would.
  assign c       = end_of_input_i ? CH_LF : text_byte_i;
  assign kept    = accept_i && !halted_q && (c != CH_SPACE);
  assign c_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign c_neg   = (c == CH_MINUS);
  assign c_sign  = (c == CH_PLUS) || c_neg;

  // Where a term or a comparator may start.
  assign toc_run = kept && (((phase_q == PH_LINE_START) && (c != CH_LF) && (c != CH_STAR)
                             && (c != CH_M)) || (phase_q == PH_TERM_START)
                            || ((phase_q == PH_TERM_VAR) && !c_digit));
  // Where a constant digit or the closing semicolon may follow.
  assign cc_run  = kept && (((phase_q == PH_CONST_SIGN) && !c_sign)
                            || (phase_q == PH_CONST_DIG));

  // Saturating decimal accumulate: acc*10 + digit.
  assign prod    = ((NUMBER_BITS+4)'(acc_q) << 3) + ((NUMBER_BITS+4)'(acc_q) << 1)
                 + (NUMBER_BITS+4)'(c[3:0]);
  assign acc_dig = (prod > (NUMBER_BITS+4)'(NUM_MAX)) ? NUM_MAX : prod[NUMBER_BITS-1:0];

  assign acc_ext = CMP_BITS'(acc_q);
  assign var_val = (acc_ext > CMP_BITS'(VAR_MAX)) ? VAR_MAX : acc_ext[VARIABLE_BITS-1:0];

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    obj_d   = obj_q;
    if (kept) begin
      case (phase_q)
        PH_LINE_START: begin
          if (c == CH_STAR) begin
            phase_d = PH_SKIP;
          end else if (c == CH_M) begin
            phase_d = PH_OBJ_M;
            obj_d   = 2'd1;
          end
        end
        PH_SKIP: begin
          if (c == CH_LF) phase_d = PH_LINE_START;
        end
        PH_OBJ_M: begin
          obj_d = 2'd2;
          if (c == CH_I) phase_d = PH_OBJ_MIN;
          else if (c == CH_A) phase_d = PH_OBJ_MAX;
        end
        PH_OBJ_MIN, PH_OBJ_MAX: begin
          if (obj_q == 2'd2) begin
            obj_d = 2'd3;
          end else if (c == CH_COLON) begin
            obj_d   = 2'd0;
            phase_d = PH_SKIP;
          end
        end
        PH_TERM_COEF: begin
          if (c == CH_X) phase_d = PH_TERM_VAR;
        end
        PH_CMP_GE: begin
          if (c == CH_EQ) phase_d = PH_CONST_SIGN;
        end
        PH_CONST_SIGN: begin
          phase_d = PH_CONST_DIG;
        end
        PH_TERM_START, PH_TERM_VAR, PH_CONST_DIG: begin
        end
        default: begin
          phase_d = PH_LINE_START;
        end
      endcase
      if (toc_run) begin
        if (c_sign) phase_d = PH_TERM_COEF;
        else if (c == CH_EQ) phase_d = PH_CONST_SIGN;
        else if (c == CH_GT) phase_d = PH_CMP_GE;
      end
      if (cc_run && (c == CH_SEMI)) phase_d = PH_SKIP;
    end
  end

  // Datapath updates and result flags.
  always_comb begin
    acc_d    = acc_q;
    held_d   = held_q;
    tneg_d   = tneg_q;
    cneg_d   = cneg_q;
    eq_d     = eq_q;
    maxv_d   = maxv_q;
    cnt_d    = cnt_q;
    term_v   = 1'b0;
    cend_v   = 1'b0;
    err_v    = 1'b0;
    err_code = ERR_NONE;
    if (kept) begin
      case (phase_q)
        PH_LINE_START: begin
          if (toc_run) begin
            eq_d   = 1'b0;
            cneg_d = 1'b0;
            tneg_d = 1'b0;
            acc_d  = '0;
            held_d = '0;
          end
        end
        PH_OBJ_M: begin
          if ((c != CH_I) && (c != CH_A)) begin
            err_v    = 1'b1;
            err_code = ERR_BAD_CMP;
          end
        end
        PH_OBJ_MIN: begin
          if (c != ((obj_q == 2'd2) ? CH_N : CH_COLON)) begin
            err_v    = 1'b1;
            err_code = ERR_BAD_CMP;
          end
        end
        PH_OBJ_MAX: begin
          if (c != ((obj_q == 2'd2) ? CH_X : CH_COLON)) begin
            err_v    = 1'b1;
            err_code = ERR_BAD_CMP;
          end
        end
        PH_TERM_COEF: begin
          if (c_digit) begin
            acc_d = acc_dig;
          end else if (c == CH_X) begin
            held_d = acc_q;
            acc_d  = '0;
          end else begin
            err_v    = 1'b1;
            err_code = ERR_MISSING_X;
          end
        end
        PH_TERM_VAR: begin
          if (c_digit) begin
            acc_d = acc_dig;
          end else begin
            term_v = 1'b1;
            if (var_val > maxv_q) maxv_d = var_val;
          end
        end
        PH_CMP_GE: begin
          if (c == CH_EQ) begin
            eq_d   = 1'b0;
            acc_d  = '0;
            cneg_d = 1'b0;
          end else begin
            err_v    = 1'b1;
            err_code = ERR_BAD_CMP;
          end
        end
        PH_CONST_SIGN: begin
          if (c_sign) cneg_d = c_neg;
        end
        PH_SKIP, PH_TERM_START, PH_CONST_DIG: begin
        end
        default: begin
        end
      endcase
      if (toc_run) begin
        if (c_sign) begin
          tneg_d = c_neg;
          acc_d  = '0;
        end else if (c == CH_EQ) begin
          eq_d   = 1'b1;
          acc_d  = '0;
          cneg_d = 1'b0;
        end else if (c != CH_GT) begin
          err_v    = 1'b1;
          err_code = ERR_BAD_CMP;
        end
      end
      if (cc_run) begin
        if (c_digit) begin
          acc_d = acc_dig;
        end else if (c == CH_SEMI) begin
          cend_v = 1'b1;
          if (cnt_q != IDX_MAX) cnt_d = cnt_q + INDEX_BITS'(1);
        end else begin
          err_v    = 1'b1;
          err_code = ERR_NO_SEMI;
        end
      end
    end
    sum_v    = kept && end_of_input_i && !err_v;
    halted_d = halted_q | err_v;
  end

  // Result records. A term can only be followed by an error in the same item.
  always_comb begin
    result_t rt, rx;
    rt          = '0;
    rt.kind     = KIND_TERM;
    rt.idx      = cnt_q;
    rt.literal  = tneg_q ? ((VARIABLE_BITS+1)'(0) - (VARIABLE_BITS+1)'(var_val))
                         : (VARIABLE_BITS+1)'(var_val);
    rt.coef     = held_q;
    rt.err      = ERR_NONE;
    rx          = '0;
    rx.idx      = cnt_q;
    rx.err      = ERR_NONE;
    if (err_v) begin
      rx.kind = KIND_ERROR;
      rx.err  = err_code;
    end else if (cend_v) begin
      rx.kind     = KIND_CEND;
      rx.constant = cneg_q ? ((NUMBER_BITS+1)'(0) - (NUMBER_BITS+1)'(acc_q))
                           : (NUMBER_BITS+1)'(acc_q);
      rx.is_eq    = eq_q;
    end else begin
      rx.kind    = KIND_SUMMARY;
      rx.max_var = maxv_d;
      rx.count   = cnt_q;
    end
    rx.last = 1'b1;
    res_o.num = 2'd0;
    res_o.r0  = rx;
    res_o.r1  = rx;
    if (term_v) begin
      rt.last   = !err_v;
      res_o.r0  = rt;
      res_o.num = err_v ? 2'd2 : 2'd1;
    end else if (err_v || cend_v || sum_v) begin
      res_o.num = 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LINE_START;
      obj_q    <= '0;
      acc_q    <= '0;
      held_q   <= '0;
      tneg_q   <= 1'b0;
      cneg_q   <= 1'b0;
      eq_q     <= 1'b0;
      maxv_q   <= '0;
      cnt_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      obj_q    <= obj_d;
      acc_q    <= acc_d;
      held_q   <= held_d;
      tneg_q   <= tneg_d;
      cneg_q   <= cneg_d;
      eq_q     <= eq_d;
      maxv_q   <= maxv_d;
      cnt_q    <= cnt_d;
      halted_q <= halted_d;
    end
  end

endmodule

[src/opb_clp_out_fifo.sv]
// Four-entry result queue that takes up to two results per cycle and
// hands out one per cycle while not stalled. Depends on opb_clp_pkg.
module opb_clp_out_fifo
  import opb_clp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  result_pair_t data_i,
  output logic         room2_o,
  output logic         valid_o,
  input  logic         stall_i,
  output result_t      data_o
);

  result_t    mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;
  logic [1:0] npush;
  logic       pop;

  assign npush   = push_i ? data_i.num : 2'd0;
  assign valid_o = (cnt_q != 3'd0);
  assign pop     = valid_o && !stall_i;
  assign room2_o = (cnt_q <= 3'd2);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) mem_q[wp_q] <= data_i.r0;
    if (npush == 2'd2) mem_q[wp_q + 2'd1] <= data_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + npush;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_q + 3'(npush) - 3'(pop);
    end
  end

endmodule

[src/opb_constraint_line_parser.sv]
// Top level of the OPB constraint line parser: parser core plus result queue.
// Depends on opb_clp_pkg, opb_clp_parser and opb_clp_out_fifo.
//
// Takes constraint text one byte per item and emits term, constraint-end,
// error and summary results. One byte is accepted per clock cycle while the
// input is not stalled; the parse state updates in the cycle of acceptance
// and its results are registered in a four-entry queue that drives the output.
// The input stalls only when the queue holds more than two results, since
// one byte can produce up to two of them. After the first error the block
// ignores all input until reset.
module opb_constraint_line_parser
  import opb_clp_pkg::*;
(
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      text_byte_i,
  input  logic                            end_of_input_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      kind_o,
  output logic [INDEX_BITS-1:0]           constraint_index_o,
  output logic signed [VARIABLE_BITS:0]   literal_o,
  output logic [NUMBER_BITS-1:0]          coefficient_o,
  output logic signed [NUMBER_BITS:0]     constant_o,
  output logic                            is_equality_o,
  output logic [VARIABLE_BITS-1:0]        max_variable_o,
  output logic [INDEX_BITS-1:0]           constraint_count_o,
  output logic [1:0]                      error_code_o,
  output logic                            last_o
);

  logic         accept, room2;
  result_pair_t res;
  result_t      head;

  assign in_stall_o = !room2;
  assign accept     = in_valid_i && room2;

  opb_clp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .text_byte_i    (text_byte_i),
    .end_of_input_i (end_of_input_i),
    .res_o          (res)
  );

  opb_clp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (head)
  );

  assign kind_o             = head.kind;
  assign constraint_index_o = head.idx;
  assign literal_o          = $signed(head.literal);
  assign coefficient_o      = head.coef;
  assign constant_o         = $signed(head.constant);
  assign is_equality_o      = head.is_eq;
  assign max_variable_o     = head.max_var;
  assign constraint_count_o = head.count;
  assign error_code_o       = head.err;
  assign last_o             = head.last;

endmodule
